@@ sv/pdu_pkg.sv @@
// shared types, constants and helpers for the packed 2-bit base unpacker
package pdu_pkg;

    // width of the bases-remaining counter
    localparam int LEN_W = 32;
    // width used to compare an incoming length against the counter limit
    localparam int CMP_W = 40;
    localparam logic [CMP_W-1:0] LEN_MAX = (CMP_W'(1) << LEN_W) - CMP_W'(1);

    localparam int BASES_PER_BYTE = 4;
    localparam int CNT_W = 3;

    // ascii letters for the 2-bit base codes
    localparam logic [7:0] CHAR_A = 8'd65;
    localparam logic [7:0] CHAR_C = 8'd67;
    localparam logic [7:0] CHAR_G = 8'd71;
    localparam logic [7:0] CHAR_T = 8'd84;
    localparam logic [7:0] CHAR_ERR = 8'd0;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    // bases of one byte waiting to go out, plus their end flags
    typedef struct packed {
        logic [7:0]       bits;   // remaining bases, next one in bits 7:6
        logic [CNT_W-1:0] cnt;    // results still to send
        logic             ended;  // last result closes the read
        logic             err;    // single odd-offset error result
    } pdu_bundle_t;

    function automatic logic [7:0] base_letter(input logic [1:0] code);
        logic [7:0] c;
        case (code)
            CODE_A:  c = CHAR_A;
            CODE_C:  c = CHAR_C;
            CODE_G:  c = CHAR_G;
            CODE_T:  c = CHAR_T;
            default: c = CHAR_A;
        endcase
        return c;
    endfunction

endpackage

@@ sv/pdu_ifs.sv @@
// valid/ready channel interfaces for packed bytes and ascii bases
interface pdu_pkt_if;
    logic        valid;
    logic        ready;
    logic [7:0]  packed_byte;
    logic        read_start;
    logic [2:0]  bit_offset;
    logic [31:0] read_length;

    modport source (output valid, packed_byte, read_start, bit_offset, read_length,
                    input ready);
    modport sink   (input valid, packed_byte, read_start, bit_offset, read_length,
                    output ready);
endinterface

interface pdu_base_if;
    logic       valid;
    logic       ready;
    logic [7:0] base_char;
    logic       end_of_item;
    logic       end_of_read;
    logic       odd_offset_error;

    modport source  (output valid, base_char, end_of_item, end_of_read, odd_offset_error,
                     input ready);
    modport sink    (input valid, base_char, end_of_item, end_of_read, odd_offset_error,
                     output ready);
    modport monitor (input valid, ready, base_char, end_of_item, end_of_read,
                     odd_offset_error);
endinterface

@@ sv/pdu_unpack.sv @@
// input side: read tracking and per-byte base selection
module pdu_unpack
    import pdu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pdu_pkt_if.sink     packed_ch,
    input  logic        free,
    output logic        load,
    output pdu_bundle_t bundle
);

    logic [LEN_W-1:0] rem_reg, rem_next;
    logic             active_reg, active_next;

    logic             accept;
    logic             odd_err;
    logic [1:0]       first;
    logic [CNT_W-1:0] avail;
    logic [CMP_W-1:0] len_ext;
    logic [LEN_W-1:0] len_sat;
    logic [LEN_W-1:0] rem_sel;
    logic             act_sel;
    logic             rem_le;
    logic [CNT_W-1:0] n_take;

    assign packed_ch.ready = free;
    assign accept = packed_ch.valid && free;

    // pick up read parameters on the first byte, else continue the open read
    always_comb
    begin
        odd_err = packed_ch.read_start && packed_ch.bit_offset[0];
        first   = packed_ch.read_start ? packed_ch.bit_offset[2:1] : 2'd0;
        avail   = CNT_W'(BASES_PER_BYTE) - CNT_W'(first);
        len_ext = CMP_W'(packed_ch.read_length);
        len_sat = (len_ext > LEN_MAX) ? LEN_MAX[LEN_W-1:0] : len_ext[LEN_W-1:0];
        rem_sel = packed_ch.read_start ? len_sat : rem_reg;
        act_sel = packed_ch.read_start ? (len_sat != '0) : active_reg;
        rem_le  = rem_sel <= LEN_W'(avail);
        n_take  = rem_le ? rem_sel[CNT_W-1:0] : avail;
    end

    // next read state
    always_comb
    begin
        rem_next    = rem_reg;
        active_next = active_reg;
        if (accept)
        begin
            if (odd_err)
            begin
                rem_next    = '0;
                active_next = 1'b0;
            end
            else if (act_sel)
            begin
                rem_next    = rem_sel - LEN_W'(n_take);
                active_next = !rem_le;
            end
            else
            begin
                rem_next    = rem_sel;
                active_next = act_sel;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            rem_reg    <= rem_next;
            active_reg <= active_next;
        end
    end

    // bases of this byte handed to the output stage
    assign load = accept && (odd_err || act_sel);

    always_comb
    begin
        bundle.bits  = packed_ch.packed_byte << {first, 1'b0};
        bundle.cnt   = odd_err ? CNT_W'(1) : n_take;
        bundle.ended = odd_err ? 1'b1 : rem_le;
        bundle.err   = odd_err;
    end

endmodule

@@ sv/pdu_emit.sv @@
// output side: holds one byte's bases and sends one per cycle while base_ch.ready is high
module pdu_emit
    import pdu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  pdu_bundle_t bundle,
    output logic        free,
    pdu_base_if.source  base_ch
);

    logic [7:0]       bits_reg, bits_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ended_reg;
    logic             err_reg;
    logic             take;

    assign take = base_ch.valid && base_ch.ready;
    // room for the next item once the last pending base leaves
    assign free = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && base_ch.ready);

    // shift out one base per accepted result
    always_comb
    begin
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            bits_next = bundle.bits;
            cnt_next  = bundle.cnt;
        end
        else if (take)
        begin
            bits_next = {bits_reg[5:0], 2'b00};
            cnt_next  = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        if (load)
        begin
            ended_reg <= bundle.ended;
            err_reg   <= bundle.err;
        end
    end

    // result fields
    always_comb
    begin
        base_ch.valid            = cnt_reg != '0;
        base_ch.base_char        = err_reg ? CHAR_ERR : base_letter(bits_reg[7:6]);
        base_ch.end_of_item      = cnt_reg == CNT_W'(1);
        base_ch.end_of_read      = (cnt_reg == CNT_W'(1)) && ended_reg;
        base_ch.odd_offset_error = err_reg;
    end

endmodule

@@ sv/packed_dna_2bit_to_ascii.sv @@
// top level of the packed 2-bit base to ascii unpacker
//
// packed_ch carries one byte of a read with four 2-bit bases, bits 7:6
// first. On read_start the byte also brings bit_offset and read_length;
// offset/2 leading bases of that byte are skipped. base_ch carries one
// ascii letter per item, with end_of_item on the last letter of a byte and
// end_of_read on the last letter of the read. An odd offset gives one item
// with base_char zero and odd_offset_error set; later bytes of that read
// are dropped until the next read_start.
// The first letter of a byte appears in the cycle after the byte is taken.
// Throughput: one letter per cycle while base_ch.ready is high, set by the
// single-letter output register; bytes that make no letter are taken
// without an item. The next byte is taken in the cycle its predecessor's
// last letter leaves, so a busy stream has no gaps.
// Reset clears the read state and empties the output register.
// When the receiver stalls, the current letter holds and packed_ch.ready
// drops until the byte's last letter is taken.
module packed_dna_2bit_to_ascii
    import pdu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pdu_pkt_if.sink    packed_ch,
    pdu_base_if.source base_ch
);

    logic        load;
    logic        free;
    pdu_bundle_t bundle;

    pdu_unpack u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .packed_ch (packed_ch),
        .free      (free),
        .load      (load),
        .bundle    (bundle)
    );

    pdu_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .bundle  (bundle),
        .free    (free),
        .base_ch (base_ch)
    );

endmodule

@@ sv/pdu_checker.sv @@
// port-level checks on the result channel, bound to the top level
module pdu_checker
    import pdu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    input  logic       ready,
    input  logic [7:0] base_char,
    input  logic       end_of_item,
    input  logic       end_of_read,
    input  logic       odd_offset_error
);

    // the error item is a lone, zero-valued item that closes the read
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && odd_offset_error) |->
        (base_char == CHAR_ERR && end_of_item && end_of_read))
        else $error("error item has wrong shape");

    // a base item carries one of the four letters
    a_letter: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !odd_offset_error) |->
        (base_char == CHAR_A || base_char == CHAR_C ||
         base_char == CHAR_G || base_char == CHAR_T))
        else $error("base item is not a letter");

    // a read only ends on the last letter of a byte
    a_read_end: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && end_of_read) |-> end_of_item)
        else $error("end of read inside a byte");

    // a stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !ready) |=>
        (valid && $stable(base_char) && $stable(end_of_item)))
        else $error("stalled item changed");

endmodule

bind packed_dna_2bit_to_ascii pdu_checker u_pdu_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .valid            (base_ch.valid),
    .ready            (base_ch.ready),
    .base_char        (base_ch.base_char),
    .end_of_item      (base_ch.end_of_item),
    .end_of_read      (base_ch.end_of_read),
    .odd_offset_error (base_ch.odd_offset_error)
);
